### sv/isohlle_pkg.sv
// Shared constants, types and fixed-point helpers for the isothermal HLLE flux block.
package isohlle_pkg;

  localparam int FRAC_BITS = 16;

  // square root of cs2 * 2^FRAC_BITS, one result bit per stage
  localparam int SQ_W     = 31 + FRAC_BITS;
  localparam int SQ_STEPS = (SQ_W + 1) / 2;
  localparam int SQ_EW    = 2 * SQ_STEPS;

  // divider: 65-bit rounded numerator, 32-bit divisor, 32 quotient bits
  localparam int NUM_W     = 65;
  localparam int DIV_STEPS = 32;
  localparam int FLUX_LAT  = 6;

  localparam logic signed [63:0] MAX32    = 64'sd2147483647;
  localparam logic signed [63:0] MIN32    = -64'sd2147483648;
  localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [30:0]        rho_l;
    logic signed [31:0] vx_l;
    logic signed [31:0] vy_l;
    logic [30:0]        rho_r;
    logic signed [31:0] vx_r;
    logic signed [31:0] vy_r;
    logic [30:0]        cs2;
    logic               axis;
  } face_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [2:0]            neg;
    logic [31:0]           d;
    logic                  degen;
  } div_in_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > MAX32) r = MAX32[31:0];
    else if (v < MIN32) r = MIN32[31:0];
    else r = v[31:0];
    return r;
  endfunction

  // round to nearest (ties up), then clamp
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32((p + HALF_LSB) >>> FRAC_BITS);
  endfunction

endpackage

### sv/isohlle_sqrt.sv
// Pipelined bit-by-bit square root of the scaled squared sound speed, face carried alongside.
module isohlle_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  isohlle_pkg::face_t   in_face,
  output logic                 out_valid,
  output isohlle_pkg::face_t   out_face,
  output logic [31:0]          cs
);

  localparam int N  = isohlle_pkg::SQ_STEPS;
  localparam int EW = isohlle_pkg::SQ_EW;
  localparam int FB = isohlle_pkg::FRAC_BITS;

  logic [N-1:0]        vld;
  isohlle_pkg::face_t  face [N];
  logic [EW-1:0]       rem  [N];
  logic [EW-1:0]       root [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_step
      localparam logic [EW-1:0] BIT = EW'(1) << (2 * (N - 1 - k));
      logic [EW-1:0]      r_in;
      logic [EW-1:0]      res_in;
      logic [EW-1:0]      trial;
      isohlle_pkg::face_t f_in;
      logic               v_in;

      if (k == 0) begin : g_first
        assign r_in   = EW'({in_face.cs2, {FB{1'b0}}});
        assign res_in = '0;
        assign f_in   = in_face;
        assign v_in   = in_valid;
      end else begin : g_next
        assign r_in   = rem[k-1];
        assign res_in = root[k-1];
        assign f_in   = face[k-1];
        assign v_in   = vld[k-1];
      end

      assign trial = res_in + BIT;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv) begin
          vld[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          face[k] <= f_in;
          if (r_in >= trial) begin
            rem[k]  <= r_in - trial;
            root[k] <= (res_in >> 1) + BIT;
          end else begin
            rem[k]  <= r_in;
            root[k] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[N-1];
  assign out_face  = face[N-1];
  assign cs        = 32'(root[N-1]);

endmodule

### sv/isohlle_flux.sv
// Conserved states, physical fluxes, signal speeds and HLLE numerators in six stages.
module isohlle_flux (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  isohlle_pkg::face_t    in_face,
  input  logic [31:0]           cs,
  output logic                  out_valid,
  output isohlle_pkg::div_in_t  out_div
);

  localparam int NW = isohlle_pkg::NUM_W;

  logic [isohlle_pkg::FLUX_LAT-1:0] vld;

  // stage 1
  logic signed [31:0] s1_rho [2];
  logic signed [31:0] s1_u1  [2];
  logic signed [31:0] s1_u2  [2];
  logic signed [31:0] s1_pr  [2];
  logic signed [31:0] s1_vn  [2];
  logic signed [31:0] s1_am, s1_ap;
  logic               s1_axis;
  // stage 2
  logic signed [31:0] s2_rho [2];
  logic signed [31:0] s2_u1  [2];
  logic signed [31:0] s2_u2  [2];
  logic signed [31:0] s2_pr  [2];
  logic signed [31:0] s2_f0  [2];
  logic signed [31:0] s2_f1a [2];
  logic signed [31:0] s2_f2a [2];
  logic signed [31:0] s2_am, s2_ap, s2_apam;
  logic               s2_axis;
  // stage 3
  logic signed [31:0] s3_fl [3];
  logic signed [31:0] s3_fr [3];
  logic signed [31:0] s3_du [3];
  logic signed [31:0] s3_am, s3_ap, s3_apam;
  logic [31:0]        s3_d;
  logic               s3_degen;
  // stage 4
  logic signed [63:0] s4_tp [3];
  logic signed [63:0] s4_tm [3];
  logic signed [63:0] s4_tu [3];
  logic [31:0]        s4_d;
  logic               s4_degen;
  // stage 5
  logic signed [65:0] s5_n [3];
  logic [31:0]        s5_d;
  logic               s5_degen;

  // stage 1 inputs
  logic signed [31:0] rho_l, rho_r, cs2_s, cs_s, vn_l, vn_r;
  logic signed [33:0] lo_l, lo_r, hi_l, hi_r, amin, amax;
  logic signed [33:0] span;

  always_comb begin
    rho_l = $signed({1'b0, in_face.rho_l});
    rho_r = $signed({1'b0, in_face.rho_r});
    cs2_s = $signed({1'b0, in_face.cs2});
    cs_s  = $signed(cs);
    vn_l  = in_face.axis ? in_face.vy_l : in_face.vx_l;
    vn_r  = in_face.axis ? in_face.vy_r : in_face.vx_r;
    lo_l  = 34'(vn_l) - 34'(cs_s);
    lo_r  = 34'(vn_r) - 34'(cs_s);
    hi_l  = 34'(vn_l) + 34'(cs_s);
    hi_r  = 34'(vn_r) + 34'(cs_s);
    amin  = '0;
    if (lo_l < amin) amin = lo_l;
    if (lo_r < amin) amin = lo_r;
    amax  = '0;
    if (hi_l > amax) amax = hi_l;
    if (hi_r > amax) amax = hi_r;
    span  = 34'(s2_ap) - 34'(s2_am);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[isohlle_pkg::FLUX_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: momenta, pressures, outer speeds
      s1_rho[0] <= rho_l;
      s1_rho[1] <= rho_r;
      s1_u1[0]  <= isohlle_pkg::mulq(rho_l, in_face.vx_l);
      s1_u1[1]  <= isohlle_pkg::mulq(rho_r, in_face.vx_r);
      s1_u2[0]  <= isohlle_pkg::mulq(rho_l, in_face.vy_l);
      s1_u2[1]  <= isohlle_pkg::mulq(rho_r, in_face.vy_r);
      s1_pr[0]  <= isohlle_pkg::mulq(rho_l, cs2_s);
      s1_pr[1]  <= isohlle_pkg::mulq(rho_r, cs2_s);
      s1_vn[0]  <= vn_l;
      s1_vn[1]  <= vn_r;
      s1_am     <= isohlle_pkg::sat32(64'(amin));
      s1_ap     <= isohlle_pkg::sat32(64'(amax));
      s1_axis   <= in_face.axis;

      // stage 2: advective fluxes and ap*am
      for (int s = 0; s < 2; s++) begin
        s2_rho[s] <= s1_rho[s];
        s2_u1[s]  <= s1_u1[s];
        s2_u2[s]  <= s1_u2[s];
        s2_pr[s]  <= s1_pr[s];
        s2_f0[s]  <= isohlle_pkg::mulq(s1_vn[s], s1_rho[s]);
        s2_f1a[s] <= isohlle_pkg::mulq(s1_vn[s], s1_u1[s]);
        s2_f2a[s] <= isohlle_pkg::mulq(s1_vn[s], s1_u2[s]);
      end
      s2_am   <= s1_am;
      s2_ap   <= s1_ap;
      s2_apam <= isohlle_pkg::mulq(s1_ap, s1_am);
      s2_axis <= s1_axis;

      // stage 3: add pressure on the normal component, state jumps, span
      s3_fl[0] <= s2_f0[0];
      s3_fr[0] <= s2_f0[1];
      s3_fl[1] <= isohlle_pkg::sat32(64'(s2_f1a[0]) + (s2_axis ? 64'sd0 : 64'(s2_pr[0])));
      s3_fr[1] <= isohlle_pkg::sat32(64'(s2_f1a[1]) + (s2_axis ? 64'sd0 : 64'(s2_pr[1])));
      s3_fl[2] <= isohlle_pkg::sat32(64'(s2_f2a[0]) + (s2_axis ? 64'(s2_pr[0]) : 64'sd0));
      s3_fr[2] <= isohlle_pkg::sat32(64'(s2_f2a[1]) + (s2_axis ? 64'(s2_pr[1]) : 64'sd0));
      s3_du[0] <= isohlle_pkg::sat32(64'(s2_rho[0]) - 64'(s2_rho[1]));
      s3_du[1] <= isohlle_pkg::sat32(64'(s2_u1[0]) - 64'(s2_u1[1]));
      s3_du[2] <= isohlle_pkg::sat32(64'(s2_u2[0]) - 64'(s2_u2[1]));
      s3_am    <= s2_am;
      s3_ap    <= s2_ap;
      s3_apam  <= s2_apam;
      s3_d     <= span[31:0];
      s3_degen <= (span == 34'sd0);

      // stage 4: full-precision products
      for (int q = 0; q < 3; q++) begin
        s4_tp[q] <= 64'(s3_fl[q]) * 64'(s3_ap);
        s4_tm[q] <= 64'(s3_fr[q]) * 64'(s3_am);
        s4_tu[q] <= 64'(s3_du[q]) * 64'(s3_apam);
      end
      s4_d     <= s3_d;
      s4_degen <= s3_degen;

      // stage 5: numerator at 2F fraction bits
      for (int q = 0; q < 3; q++) begin
        s5_n[q] <= 66'(s4_tp[q]) - 66'(s4_tm[q]) - 66'(s4_tu[q]);
      end
      s5_d     <= s4_d;
      s5_degen <= s4_degen;

      // stage 6: magnitude plus half the divisor
      for (int q = 0; q < 3; q++) begin
        out_div.neg[q] <= s5_n[q][65];
        out_div.num[q] <= (s5_n[q][65] ? NW'(-s5_n[q]) : NW'(s5_n[q]))
                          + NW'(s5_d >> 1);
      end
      out_div.d     <= s5_d;
      out_div.degen <= s5_degen;
    end
  end

  assign out_valid = vld[isohlle_pkg::FLUX_LAT-1];

endmodule

### sv/isohlle_div.sv
// Three-lane pipelined restoring divider with signed saturation of the quotients.
module isohlle_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  isohlle_pkg::div_in_t  in_div,
  output logic                  out_valid,
  output logic [2:0][31:0]      flux,
  output logic                  degen
);

  localparam int N = isohlle_pkg::DIV_STEPS;

  typedef struct packed {
    logic [2:0]  ovf;
    logic [2:0]  neg;
    logic [31:0] d;
    logic        degen;
  } div_meta_t;

  logic [N+1:0]     vld;
  div_meta_t        meta [N+1];
  logic [2:0][31:0] rem  [N+1];
  logic [2:0][31:0] quo  [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N:0], in_valid};
    end
  end

  // load: upper half is the first partial remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int q = 0; q < 3; q++) begin
        rem[0][q]      <= in_div.num[q][63:32];
        quo[0][q]      <= in_div.num[q][31:0];
        meta[0].ovf[q] <= in_div.num[q][64:32] >= {1'b0, in_div.d};
      end
      meta[0].neg   <= in_div.neg;
      meta[0].d     <= in_div.d;
      meta[0].degen <= in_div.degen;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= N; k++) begin : g_step
      logic [2:0][32:0] shifted;
      logic [2:0]       ge;
      always_comb begin
        for (int q = 0; q < 3; q++) begin
          shifted[q] = {rem[k-1][q], quo[k-1][q][31]};
          ge[q]      = shifted[q] >= {1'b0, meta[k-1].d};
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          meta[k] <= meta[k-1];
          for (int q = 0; q < 3; q++) begin
            rem[k][q] <= ge[q] ? 32'(shifted[q] - {1'b0, meta[k-1].d})
                               : shifted[q][31:0];
            quo[k][q] <= {quo[k-1][q][30:0], ge[q]};
          end
        end
      end
    end
  endgenerate

  // clamp and force zero on an empty speed span
  always_ff @(posedge clk) begin
    if (adv) begin
      degen <= meta[N].degen;
      for (int q = 0; q < 3; q++) begin
        if (meta[N].degen) begin
          flux[q] <= '0;
        end else if (!meta[N].neg[q]) begin
          flux[q] <= (meta[N].ovf[q] || quo[N][q][31]) ? 32'h7fff_ffff : quo[N][q];
        end else begin
          flux[q] <= (meta[N].ovf[q] || (quo[N][q] > 32'h8000_0000)) ? 32'h8000_0000
                                                                      : -quo[N][q];
        end
      end
    end
  end

  assign out_valid = vld[N+1];

endmodule

### sv/isothermal_hlle_flux.sv
// Top level: isothermal HLLE face flux, square root, flux pipeline and divider.
// Throughput: one face per cycle when not stalled; all stages are registers and advance as one.
// The whole pipeline holds while the output register is full and not taken.
// Reset (rst, synchronous, active high) clears the valid bits only; data registers keep garbage.
module isothermal_hlle_flux (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // left_density, left_velocity_x, left_velocity_y, right_density,
  // right_velocity_x, right_velocity_y, sound_speed_sq, zero pad
  input  logic [223:0] s_tdata,
  // face_axis
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // mass_flux, momentum_x_flux, momentum_y_flux
  output logic [95:0]  m_tdata,
  // degenerate
  output logic         m_tuser
);

  logic                  adv;
  isohlle_pkg::face_t    face;
  isohlle_pkg::face_t    sq_face;
  logic                  sq_valid;
  logic [31:0]           cs;
  logic                  fx_valid;
  isohlle_pkg::div_in_t  fx_div;
  logic [2:0][31:0]      flux;

  // advance every stage when the output register is empty or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // unpack the input transfer
  always_comb begin
    face.rho_l = s_tdata[30:0];
    face.vx_l  = s_tdata[62:31];
    face.vy_l  = s_tdata[94:63];
    face.rho_r = s_tdata[125:95];
    face.vx_r  = s_tdata[157:126];
    face.vy_r  = s_tdata[189:158];
    face.cs2   = s_tdata[220:190];
    face.axis  = s_tuser;
  end

  // sound speed, one root bit per stage
  isohlle_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .in_face   (face),
    .out_valid (sq_valid),
    .out_face  (sq_face),
    .cs        (cs)
  );

  // states, fluxes, wave speeds and numerators
  isohlle_flux u_flux (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_face   (sq_face),
    .cs        (cs),
    .out_valid (fx_valid),
    .out_div   (fx_div)
  );

  // divide by the speed span; its last stage is the output register
  isohlle_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fx_valid),
    .in_div    (fx_div),
    .out_valid (m_tvalid),
    .flux      (flux),
    .degen     (m_tuser)
  );

  assign m_tdata = flux;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the isothermal HLLE face flux block.
`timescale 1ns / 100ps

module tb_top;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [31:0] mass;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic               degen;
  } flux_t;

  // Round-to-nearest Q product with clamp to the signed 32-bit range.
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (longint'(1) <<< (isohlle_pkg::FRAC_BITS - 1));
    p = p >>> isohlle_pkg::FRAC_BITS;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Bit-by-bit integer square root over 32 steps.
  function automatic longint root_q(longint unsigned r);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (r >= res + bitv) begin
        r = r - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // Expected HLLE flux for one face.
  function automatic flux_t hlle_flux(isohlle_pkg::face_t fc);
    flux_t fx;
    longint rho[2], vx[2], vy[2], vn[2], cons[2][3], phys[2][3];
    longint cs2, cs, am, ap, span, apam, pr, du, r;
    logic signed [127:0] acc;
    logic [127:0] mag, quo;
    cs2 = longint'(fc.cs2);
    cs = root_q(longint'(cs2) << isohlle_pkg::FRAC_BITS);
    rho[0] = fc.rho_l; vx[0] = fc.vx_l; vy[0] = fc.vy_l;
    rho[1] = fc.rho_r; vx[1] = fc.vx_r; vy[1] = fc.vy_r;
    for (int s = 0; s < 2; s++) begin
      vn[s] = fc.axis ? vy[s] : vx[s];
      cons[s][0] = rho[s];
      cons[s][1] = qmul(rho[s], vx[s]);
      cons[s][2] = qmul(rho[s], vy[s]);
      pr = qmul(rho[s], cs2);
      phys[s][0] = qmul(vn[s], cons[s][0]);
      phys[s][1] = clamp32(qmul(vn[s], cons[s][1]) + (fc.axis ? 0 : pr));
      phys[s][2] = clamp32(qmul(vn[s], cons[s][2]) + (fc.axis ? pr : 0));
    end
    am = 0;
    if (vn[0] - cs < am) am = vn[0] - cs;
    if (vn[1] - cs < am) am = vn[1] - cs;
    ap = 0;
    if (vn[0] + cs > ap) ap = vn[0] + cs;
    if (vn[1] + cs > ap) ap = vn[1] + cs;
    am = clamp32(am);
    ap = clamp32(ap);
    span = ap - am;
    if (span == 0) begin
      fx.mass = 0; fx.mom_x = 0; fx.mom_y = 0; fx.degen = 1'b1;
      return fx;
    end
    apam = qmul(ap, am);
    for (int q = 0; q < 3; q++) begin
      du = clamp32(cons[0][q] - cons[1][q]);
      acc = 128'(phys[0][q]) * 128'(ap) - 128'(phys[1][q]) * 128'(am)
          - 128'(du) * 128'(apam);
      mag = acc < 0 ? 128'(-acc) : 128'(acc);
      quo = (mag + 128'(span >> 1)) / 128'(span);
      if (acc >= 0) r = quo > 128'd2147483647 ? 64'sd2147483647 : longint'(quo);
      else r = quo > 128'd2147483648 ? -64'sd2147483648 : -longint'(quo);
      case (q)
        0: fx.mass = r[31:0];
        1: fx.mom_x = r[31:0];
        default: fx.mom_y = r[31:0];
      endcase
    end
    fx.degen = 1'b0;
    return fx;
  endfunction

  int err_count = 0;

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  class flux_scoreboard;
    flux_t pending[$];

    function void note_face(isohlle_pkg::face_t fc);
      pending.push_back(hlle_flux(fc));
    endfunction

    task check_flux(logic [95:0] data, logic degen);
      flux_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want.mass)
        report($sformatf("mass_flux %h want %h", data[31:0], want.mass));
      if (data[63:32] !== want.mom_x)
        report($sformatf("momentum_x_flux %h want %h", data[63:32], want.mom_x));
      if (data[95:64] !== want.mom_y)
        report($sformatf("momentum_y_flux %h want %h", data[95:64], want.mom_y));
      if (degen !== want.degen)
        report($sformatf("degenerate %b want %b", degen, want.degen));
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [95:0]  m_tdata;
  logic         m_tuser;

  isothermal_hlle_flux dut (.*);

  initial forever #2 clk = ~clk;

  flux_scoreboard sb = new();
  isohlle_pkg::face_t faces[$];
  bit    calm = 0;      // no idling on either side while set
  int    quiet = 0;

  function automatic logic [223:0] pack_face(isohlle_pkg::face_t fc);
    return {3'b000, fc.cs2, fc.vy_r, fc.vx_r, fc.rho_r, fc.vy_l, fc.vx_l, fc.rho_l};
  endfunction

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;  // about +-2
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic isohlle_pkg::face_t rand_face();
    isohlle_pkg::face_t fc;
    int m;
    m = $urandom_range(0, 9);
    m = m < 6 ? 1 : (m < 8 ? 2 : (m < 9 ? 0 : 3));
    fc.rho_l = m == 1 ? 31'($urandom_range(0, 32'h0008_0000)) : 31'(rand_word(m));
    fc.rho_r = m == 1 ? 31'($urandom_range(0, 32'h0008_0000)) : 31'(rand_word(m));
    fc.vx_l = rand_word(m); fc.vy_l = rand_word(m);
    fc.vx_r = rand_word(m); fc.vy_r = rand_word(m);
    case ($urandom_range(0, 7))
      0: fc.cs2 = '0;
      1: fc.cs2 = 31'h7fff_ffff;
      2, 3: fc.cs2 = 31'($urandom());
      default: fc.cs2 = 31'($urandom_range(0, 32'h0004_0000));
    endcase
    fc.axis = 1'($urandom_range(0, 1));
    return fc;
  endfunction

  function automatic isohlle_pkg::face_t mk(logic [30:0] rl, logic [31:0] xl,
                                            logic [31:0] yl, logic [30:0] rr,
                                            logic [31:0] xr, logic [31:0] yr,
                                            logic [30:0] c2, logic ax);
    isohlle_pkg::face_t fc;
    fc.rho_l = rl; fc.vx_l = xl; fc.vy_l = yl;
    fc.rho_r = rr; fc.vx_r = xr; fc.vy_r = yr;
    fc.cs2 = c2; fc.axis = ax;
    return fc;
  endfunction

  // Drive one face and hold it until the transfer.
  task automatic send_face(isohlle_pkg::face_t fc);
    while (!calm && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_face(fc);
    s_tuser  <= fc.axis;
    do @(posedge clk); while (!s_tready);
  endtask

  // Note input transfers and check results at the sampling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_face(faces.pop_front());
      if (m_tvalid && m_tready)
        sb.check_flux(m_tdata, m_tuser);
      quiet <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : quiet + 1;
      m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
    end
  end

  // Stall watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (quiet >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    isohlle_pkg::face_t dir[$];
    isohlle_pkg::face_t fc;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed faces: still flow with zero sound speed (zero span), extremes, both axes.
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(31'h10000, 0, 0, 31'h10000, 0, 0, 0, 1));
    dir.push_back(mk(31'h10000, 32'h10000, 0, 31'h20000, 32'hffff0000, 0, 31'h10000, 0));
    dir.push_back(mk(31'h10000, 0, 32'h10000, 31'h20000, 0, 32'hffff0000, 31'h10000, 1));
    dir.push_back(mk(31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0));
    dir.push_back(mk(31'h7fffffff, 32'h80000000, 32'h80000000,
                     31'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff, 1));
    dir.push_back(mk(31'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff,
                     32'h80000000, 0, 0));
    dir.push_back(mk(0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h80000000,
                     32'h7fffffff, 0, 1));
    dir.push_back(mk(31'h30000, 32'h20000, 32'h8000, 31'h30000, 32'h20000, 32'h8000, 0, 0));
    dir.push_back(mk(31'h30000, 32'hfffe0000, 32'h8000, 31'h10000, 32'hfffd0000, 0, 0, 0));
    dir.push_back(mk(31'h1, 32'h1, 32'hffffffff, 31'h1, 32'hffffffff, 32'h1, 31'h1, 0));
    dir.push_back(mk(31'h18000, 32'h8000, 32'h4000, 31'h8000, 32'hffffc000, 32'h2000,
                     31'h40000, 1));
    foreach (dir[i]) begin
      faces.push_back(dir[i]);
      send_face(dir[i]);
    end
    for (int n = 0; n < 1050; n++) begin
      calm = (n >= 400 && n < 550);
      fc = rand_face();
      faces.push_back(fc);
      send_face(fc);
    end
    calm = 0;
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

### filelist.f
sv/isohlle_pkg.sv
sv/isohlle_sqrt.sv
sv/isohlle_flux.sv
sv/isohlle_div.sv
sv/isothermal_hlle_flux.sv
verif/tb_top.sv
